@@ rtl/sha_pkg.sv @@
// ============================================================================
// SHA-256 engine package
// Shared types and constants for the SHA-256 hash engine.
// ============================================================================
package sha_pkg;

    typedef logic [31:0] word_t;

    // One beat passed from the front part to the core through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } sha_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } core_state_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_POS   = 56;
    localparam int         BLK_BYTES = 64;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror32(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha256_hash_engine.sv @@
// A byte that fills a block holds the core through the rounds and fold;
// a message end runs padding and compression, then eight digest beats.
// The core takes one byte per cycle while idle, and no new byte while it pads, compresses or emits.
// Reset: synchronous, active low; restores the initial hash and empties the queue.
// ============================================================================
// SHA-256 hash engine
// Byte-stream SHA-256 with a front stage, a beat queue and a compression core.
// ============================================================================
module sha256_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_word_index,
    output logic [31:0] m_digest_word,
    output logic        m_last_word
);
    import sha_pkg::*;

    sha_beat_t f_beat, c_beat;
    logic      f_valid, f_ready, c_valid, c_ready;

    sha_front u_front (
        .aclk, .aresetn, .s_data_byte, .s_byte_present, .s_message_end,
        .s_valid, .s_ready, .q_valid(f_valid), .q_ready(f_ready), .q_beat(f_beat)
    );

    sha_beat_fifo u_fifo (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_beat(f_beat),
        .rd_valid(c_valid), .rd_ready(c_ready), .rd_beat(c_beat)
    );

    sha_core u_core (
        .aclk, .aresetn, .in_valid(c_valid), .in_ready(c_ready), .in_beat(c_beat),
        .m_valid, .m_ready, .m_word_index, .m_digest_word, .m_last_word
    );
endmodule

@@ rtl/sha_beat_fifo.sv @@
// ============================================================================
// SHA-256 input queue
// Four-entry queue between the input front and the compression core.
// ============================================================================
module sha_beat_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  sha_pkg::sha_beat_t wr_beat,
    output logic              rd_valid,
    input  logic              rd_ready,
    output sha_pkg::sha_beat_t rd_beat
);
    import sha_pkg::*;

    sha_beat_t   mem_reg [4];
    logic [1:0]  wptr_reg, rptr_reg;
    logic [2:0]  count_reg;
    logic        push, pop;

    assign wr_ready = (count_reg != 3'd4);
    assign rd_valid = (count_reg != 3'd0);
    assign rd_beat  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wr_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 2'd1;
            if (pop)  rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4) else $error("queue count beyond depth");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 3'd4 |-> !wr_ready) else $error("write allowed while full");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 3'd1)
        else $error("count did not advance on write");
`endif
endmodule

@@ rtl/sha_core.sv @@
// ============================================================================
// SHA-256 compression core
// Collects bytes into a block, pads, runs 64 rounds and emits the digest.
// ============================================================================
module sha_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha_pkg::sha_beat_t in_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_word_index,
    output logic [31:0]        m_digest_word,
    output logic               m_last_word
);
    import sha_pkg::*;

    core_state_t state_reg, state_next;

    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    word_t       blk_reg [16];  // block held as 16 big-endian words
    logic [63:0] bits_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  widx_reg;
    logic        closing_reg;   // message closes after the current compression
    logic        second_reg;    // padding still owes the length block
    logic        padded_reg;    // pad marker already placed for this message

    word_t w_new, t1, t2, s0, s1, wcur;
    logic  take, start_cmp, last_rnd;

    // Schedule word: first 16 rounds read the block, then expand.
    always_comb begin
        s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        if (rnd_reg < 6'd16) begin
            wcur = blk_reg[rnd_reg[3:0]];
        end else begin
            wcur = w_reg[0] + s0 + w_reg[9] + s1;
        end
        w_new = wcur;
        t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + wcur;
        t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign take     = in_valid && in_ready;
    assign last_rnd = (rnd_reg == 6'd63);
    // A byte that fills the block is compressed at once, before any padding.
    assign start_cmp = take && in_beat.present && fill_reg == 6'd63;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start_cmp)                 state_next = ST_ROUND;
                      else if (take && in_beat.last) state_next = ST_PAD;
            ST_PAD:   state_next = ST_ROUND;
            ST_ROUND: if (last_rnd)                  state_next = ST_FOLD;
            ST_FOLD:  if (second_reg || (closing_reg && !padded_reg))
                                                     state_next = ST_PAD;
                      else if (closing_reg)          state_next = ST_EMIT;
                      else                           state_next = ST_IDLE;
            ST_EMIT:  if (m_ready && widx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = (state_reg == ST_IDLE);
        m_valid  = (state_reg == ST_EMIT);
    end

    assign m_word_index  = widx_reg;
    assign m_digest_word = h_reg[widx_reg];
    assign m_last_word   = (widx_reg == 3'd7);

    // Byte store and padding writes.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && take) begin
            if (in_beat.present) begin
                blk_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'd0} +: 8] <= in_beat.data;
            end
        end else if (state_reg == ST_PAD) begin
            // Pad marker, zero fill and, when it fits, the bit length.
            for (int i = 0; i < BLK_BYTES; i++) begin
                if (second_reg && fill_reg == 6'd0) begin
                    blk_reg[4'(i >> 2)][8*(3 - (i & 3)) +: 8] <=
                        (i >= LEN_POS) ? bits_reg[8*(63-i) +: 8] : 8'd0;
                end else if (6'(i) == fill_reg) begin
                    blk_reg[4'(i >> 2)][8*(3 - (i & 3)) +: 8] <= PAD_BYTE;
                end else if (6'(i) > fill_reg) begin
                    blk_reg[4'(i >> 2)][8*(3 - (i & 3)) +: 8] <=
                        (i >= LEN_POS && fill_reg < 6'(LEN_POS))
                        ? bits_reg[8*(63-i) +: 8] : 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            for (int i = 1; i < 8; i++) v_reg[i] <= v_reg[i-1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end else begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bits_reg    <= '0;
            fill_reg    <= '0;
            rnd_reg     <= '0;
            widx_reg    <= '0;
            closing_reg <= 1'b0;
            second_reg  <= 1'b0;
            padded_reg  <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        logic [6:0] f;
                        f = {1'b0, fill_reg} + {6'd0, in_beat.present};
                        if (in_beat.present) bits_reg <= bits_reg + 64'd8;
                        fill_reg    <= f[5:0];
                        closing_reg <= in_beat.last;
                        padded_reg  <= 1'b0;
                        // Spill: length no longer fits after the pad marker.
                        second_reg  <= in_beat.last && !f[6] && f[5:0] >= 6'(LEN_POS);
                        rnd_reg     <= '0;
                    end
                end
                ST_PAD: begin
                    rnd_reg    <= '0;
                    padded_reg <= 1'b1;
                end
                ST_ROUND: begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    rnd_reg <= '0;
                    if (second_reg) begin
                        // Spill block done; the length block follows.
                        fill_reg <= '0;
                    end else begin
                        second_reg <= 1'b0;
                    end
                    widx_reg <= '0;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
                            bits_reg    <= '0;
                            fill_reg    <= '0;
                            closing_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_PAD && second_reg && fill_reg == 6'd0) begin
                second_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> closing_reg) else $error("digest without message end");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !in_ready) else $error("beat taken while busy");
    a_round_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FOLD |-> $past(rnd_reg) == 6'd63)
        else $error("fold before round 63");
`endif
endmodule

@@ rtl/sha_front.sv @@
// ============================================================================
// SHA-256 input front
// Accepts input beats and packs them for the queue; drops empty beats.
// ============================================================================
module sha_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_data_byte,
    input  logic               s_byte_present,
    input  logic               s_message_end,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               q_valid,
    input  logic               q_ready,
    output sha_pkg::sha_beat_t q_beat
);
    import sha_pkg::*;

    sha_beat_t beat_reg;
    logic      full_reg;
    logic      useful;

    // A beat with neither a byte nor an end marker does nothing.
    assign useful  = s_byte_present || s_message_end;
    assign s_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_beat  = beat_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg.data    <= s_data_byte;
            beat_reg.present <= s_byte_present;
            beat_reg.last    <= s_message_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_ready) begin
            full_reg <= s_valid && useful;
        end
    end
endmodule
